FILE: rtl/nrr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_pkg
// Shared types, constants and fixed-point helpers of the neuron recharge block.
// ----------------------------------------------------------------------------
package nrr_pkg;

    localparam int POT_W  = 21;   // potential, signed Q.12
    localparam int AGE_W  = 16;   // firing age
    localparam int FAC_W  = 20;   // recovery and gain factors, Q.16
    localparam int UNIT_W = 17;   // factors limited to one, Q1.16
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 21;

    localparam logic [UNIT_W-1:0] ONE_Q16  = 17'h10000;
    localparam logic [UNIT_W-1:0] HALF_Q16 = 17'h08000;

    // Register indexes of the configuration port.
    localparam logic [IDX_W-1:0] CFG_REST_POTENTIAL = 3'd0;
    localparam logic [IDX_W-1:0] CFG_LEAK_FACTOR    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_RECOVERY_RESET = 3'd2;
    localparam logic [IDX_W-1:0] CFG_RECOVERY_DECAY = 3'd3;
    localparam logic [IDX_W-1:0] CFG_GAIN_RESET     = 3'd4;
    localparam logic [IDX_W-1:0] CFG_GAIN_DECAY     = 3'd5;

    typedef struct packed {
        logic [POT_W-1:0]  rest_potential;
        logic [UNIT_W-1:0] leak_factor;
        logic [FAC_W-1:0]  recovery_reset;
        logic [UNIT_W-1:0] recovery_decay;
        logic [FAC_W-1:0]  gain_reset;
        logic [UNIT_W-1:0] gain_decay;
    } t_cfg;

    // One power lane: running product and running square.
    typedef struct packed {
        logic [UNIT_W-1:0] p;
        logic [UNIT_W-1:0] base;
    } t_lane;

    typedef struct packed {
        logic [POT_W-1:0] pot;
        logic [AGE_W-1:0] age;
        logic             age_zero;
        t_lane            m;
        t_lane            h;
    } t_pow;

    typedef struct packed {
        logic [POT_W-1:0] pot;
        logic [FAC_W-1:0] m;
        logic [FAC_W-1:0] h;
    } t_fac;

    // Q1.16 product of two values no larger than one, rounded to nearest.
    function automatic logic [UNIT_W-1:0] mul_q16(input logic [UNIT_W-1:0] a,
                                                  input logic [UNIT_W-1:0] b);
        logic [2*UNIT_W:0] prod;
        prod = {{(UNIT_W+1){1'b0}}, a} * {{(UNIT_W+1){1'b0}}, b}
             + {{(UNIT_W+1){1'b0}}, HALF_Q16};
        return prod[UNIT_W+15:16];
    endfunction

    // Limits a factor register to one.
    function automatic logic [UNIT_W-1:0] clamp_one(input logic [UNIT_W-1:0] f);
        return (f > ONE_Q16) ? ONE_Q16 : f;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/neuron_recovery_recharge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// neuron_recovery_recharge
// Recovery and gain factors from the firing age, and the recharged potential.
// ----------------------------------------------------------------------------
// Each request on the slave stream carries one neuron's potential and firing
// age; each request on the master stream carries its recharged potential and
// the recovery and gain factors. One result leaves for every request taken.
// The block accepts one request per cycle unless a finished result waits at the
// output. Its stages are one input stage, one square-and-multiply stage per age
// bit (both powers run side by side), one stage that forms the factors, and
// three recharge stages whose last is the output register.
// A stall on the master side freezes the whole pipeline at once: ready on the
// slave side is low exactly while a finished result waits and is not taken,
// so nothing is lost or repeated. The configuration registers are written at
// any edge with the write enable high and must only change while the pipeline
// holds no request. Reset clears all valid bits and loads the register
// defaults: rest potential zero, leak and both reset factors one, both decays
// zero.
// ----------------------------------------------------------------------------
module neuron_recovery_recharge #(
    parameter int AGE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream: potential [20:0], firing_age [36:21], zero fill [39:37].
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [39:0] i_s_axis_tdata,
    // Master stream: new_potential [20:0], recovery_factor [40:21],
    // gain_factor [60:41], zero fill [63:61].
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [63:0]      o_m_axis_tdata,
    // Configuration write port.
    input  wire logic                        i_cfg_we,
    input  wire logic [nrr_pkg::IDX_W-1:0]   i_cfg_index,
    input  wire logic [nrr_pkg::CFG_W-1:0]   i_cfg_data
);

    // Age bits above the field width are always zero, so they need no stage.
    localparam int PW = (AGE_BITS < nrr_pkg::AGE_W) ? AGE_BITS : nrr_pkg::AGE_W;
    localparam logic [nrr_pkg::AGE_W-1:0] AGE_MAX = nrr_pkg::AGE_W'((33'd1 << PW) - 33'd1);

    nrr_pkg::t_cfg r_cfg;
    logic          w_en;
    logic          w_fac_vld;
    nrr_pkg::t_fac w_fac;
    logic          w_out_vld;
    nrr_pkg::t_fac w_out;
    logic [PW:0]   w_vld;
    nrr_pkg::t_pow w_pow [0:PW];
    logic          r_in_vld;
    nrr_pkg::t_pow r_in;
    nrr_pkg::t_pow n_in;
    logic [nrr_pkg::AGE_W-1:0] in_age;

    // ---- configuration registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rest_potential <= '0;
            r_cfg.leak_factor    <= nrr_pkg::ONE_Q16;
            r_cfg.recovery_reset <= nrr_pkg::FAC_W'(nrr_pkg::ONE_Q16);
            r_cfg.recovery_decay <= '0;
            r_cfg.gain_reset     <= nrr_pkg::FAC_W'(nrr_pkg::ONE_Q16);
            r_cfg.gain_decay     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nrr_pkg::CFG_REST_POTENTIAL: begin
                    r_cfg.rest_potential <= i_cfg_data[nrr_pkg::POT_W-1:0];
                end
                nrr_pkg::CFG_LEAK_FACTOR: begin
                    r_cfg.leak_factor <= i_cfg_data[nrr_pkg::UNIT_W-1:0];
                end
                nrr_pkg::CFG_RECOVERY_RESET: begin
                    r_cfg.recovery_reset <= i_cfg_data[nrr_pkg::FAC_W-1:0];
                end
                nrr_pkg::CFG_RECOVERY_DECAY: begin
                    r_cfg.recovery_decay <= i_cfg_data[nrr_pkg::UNIT_W-1:0];
                end
                nrr_pkg::CFG_GAIN_RESET: begin
                    r_cfg.gain_reset <= i_cfg_data[nrr_pkg::FAC_W-1:0];
                end
                nrr_pkg::CFG_GAIN_DECAY: begin
                    r_cfg.gain_decay <= i_cfg_data[nrr_pkg::UNIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves together unless a result waits at the output.
    assign w_en            = !w_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---- input stage: age saturation and power lane start values ----
    always_comb begin
        in_age          = i_s_axis_tdata[36:21];
        n_in.pot        = i_s_axis_tdata[20:0];
        n_in.age_zero   = (in_age == '0);
        n_in.age        = (in_age > AGE_MAX) ? AGE_MAX : in_age;
        n_in.m.p        = nrr_pkg::ONE_Q16;
        n_in.m.base     = nrr_pkg::clamp_one(r_cfg.recovery_decay);
        n_in.h.p        = nrr_pkg::ONE_Q16;
        n_in.h.base     = nrr_pkg::clamp_one(r_cfg.gain_decay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= n_in;
        end
    end

    assign w_vld[0] = r_in_vld;
    assign w_pow[0] = r_in;

    // ---- one square-and-multiply stage per age bit ----
    for (genvar k = 0; k < PW; k++) begin : g_pow
        nrr_pow_stage #(
            .BIT (k)
        ) u_pow (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[k]),
            .i_data  (w_pow[k]),
            .o_vld   (w_vld[k+1]),
            .o_data  (w_pow[k+1])
        );
    end

    nrr_factor u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (w_vld[PW]),
        .i_data  (w_pow[PW]),
        .o_vld   (w_fac_vld),
        .o_data  (w_fac)
    );

    nrr_recharge u_recharge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_vld   (w_fac_vld),
        .i_data  (w_fac),
        .o_vld   (w_out_vld),
        .o_data  (w_out)
    );

    assign o_m_axis_tvalid = w_out_vld;
    assign o_m_axis_tdata  = {3'b000, w_out.h, w_out.m, w_out.pot};

endmodule
`default_nettype wire

FILE: rtl/nrr_pow_stage.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_pow_stage
// One square-and-multiply step of both power lanes, for one bit of the age.
// ----------------------------------------------------------------------------
module nrr_pow_stage #(
    parameter int BIT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire nrr_pkg::t_pow i_data,
    output logic               o_vld,
    output nrr_pkg::t_pow      o_data
);

    logic          r_vld;
    nrr_pkg::t_pow r_data;
    nrr_pkg::t_pow n_data;

    always_comb begin
        n_data        = i_data;
        n_data.m.base = nrr_pkg::mul_q16(i_data.m.base, i_data.m.base);
        n_data.h.base = nrr_pkg::mul_q16(i_data.h.base, i_data.h.base);
        if (i_data.age[BIT]) begin
            n_data.m.p = nrr_pkg::mul_q16(i_data.m.p, i_data.m.base);
            n_data.h.p = nrr_pkg::mul_q16(i_data.h.p, i_data.h.base);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

FILE: rtl/nrr_factor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_factor
// Scales the reset deficit by the power and applies the special cases.
// ----------------------------------------------------------------------------
module nrr_factor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire nrr_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    input  wire nrr_pkg::t_pow i_data,
    output logic               o_vld,
    output nrr_pkg::t_fac      o_data
);

    localparam logic [nrr_pkg::FAC_W-1:0] ONE_F = 20'h10000;

    // Factor for reset r, clamped decay mu and power p.
    function automatic logic [nrr_pkg::FAC_W-1:0] fac_calc(
        input logic [nrr_pkg::FAC_W-1:0]  r,
        input logic [nrr_pkg::UNIT_W-1:0] mu,
        input logic [nrr_pkg::UNIT_W-1:0] p,
        input logic                       age_zero
    );
        logic [nrr_pkg::FAC_W-1:0]   d;
        logic [nrr_pkg::FAC_W+nrr_pkg::UNIT_W:0] prod;
        logic [nrr_pkg::FAC_W-1:0]   e;
        logic [nrr_pkg::FAC_W-1:0]   res;
        d    = (r < ONE_F) ? (ONE_F - r) : (r - ONE_F);
        prod = {{(nrr_pkg::UNIT_W+1){1'b0}}, d} * {{(nrr_pkg::FAC_W+1){1'b0}}, p}
             + {{(nrr_pkg::FAC_W+1){1'b0}}, nrr_pkg::HALF_Q16};
        e    = prod[nrr_pkg::FAC_W+15:16];
        res  = (r < ONE_F) ? (ONE_F - e) : (ONE_F + e);
        if (age_zero || r == ONE_F) begin
            res = r;
        end else if (mu == '0) begin
            res = ONE_F;
        end else if (mu == nrr_pkg::ONE_Q16) begin
            res = r;
        end
        return res;
    endfunction

    logic          r_vld;
    nrr_pkg::t_fac r_data;
    nrr_pkg::t_fac n_data;

    always_comb begin
        n_data.pot = i_data.pot;
        n_data.m   = fac_calc(i_cfg.recovery_reset, nrr_pkg::clamp_one(i_cfg.recovery_decay),
                              i_data.m.p, i_data.age_zero);
        n_data.h   = fac_calc(i_cfg.gain_reset, nrr_pkg::clamp_one(i_cfg.gain_decay),
                              i_data.h.p, i_data.age_zero);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;

endmodule
`default_nettype wire

FILE: rtl/nrr_recharge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nrr_recharge
// Three stages: leak times M and offset from rest, scaling, then saturation.
// ----------------------------------------------------------------------------
module nrr_recharge (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire nrr_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    input  wire nrr_pkg::t_fac i_data,
    output logic               o_vld,
    output nrr_pkg::t_fac      o_data
);

    localparam int DIFF_W = nrr_pkg::POT_W + 1;
    localparam int TM_W   = DIFF_W + nrr_pkg::FAC_W - 16;
    localparam int NV_W   = TM_W + 2;
    localparam logic signed [NV_W-1:0] POT_MAX = NV_W'(1048575);
    localparam logic signed [NV_W-1:0] POT_MIN = -NV_W'(1048576);

    typedef struct packed {
        logic [DIFF_W-1:0]        mag;
        logic                     neg;
        logic [nrr_pkg::FAC_W-1:0] c;
        logic [nrr_pkg::FAC_W-1:0] m;
        logic [nrr_pkg::FAC_W-1:0] h;
    } t_scale;

    typedef struct packed {
        logic [TM_W-1:0]           tm;
        logic                      neg;
        logic [nrr_pkg::FAC_W-1:0] m;
        logic [nrr_pkg::FAC_W-1:0] h;
    } t_sum;

    logic [2:0]                r_vld;
    t_scale                    r_a;
    t_sum                      r_b;
    nrr_pkg::t_fac             r_c;
    t_scale                    n_a;
    t_sum                      n_b;
    nrr_pkg::t_fac             n_c;
    logic signed [DIFF_W-1:0]  diff;
    logic [nrr_pkg::UNIT_W+nrr_pkg::FAC_W:0] c_prod;
    logic [DIFF_W+nrr_pkg::FAC_W:0]          t_prod;
    logic signed [NV_W-1:0]    t_s;
    logic signed [NV_W-1:0]    nv;

    // Stage A: c = leak * M, and the magnitude of the offset from rest.
    always_comb begin
        diff   = $signed({i_data.pot[nrr_pkg::POT_W-1], i_data.pot})
               - $signed({i_cfg.rest_potential[nrr_pkg::POT_W-1], i_cfg.rest_potential});
        c_prod = {{(nrr_pkg::FAC_W+1){1'b0}}, nrr_pkg::clamp_one(i_cfg.leak_factor)}
               * {{(nrr_pkg::UNIT_W+1){1'b0}}, i_data.m}
               + {{(nrr_pkg::FAC_W+1){1'b0}}, nrr_pkg::HALF_Q16};
        n_a.neg = diff[DIFF_W-1];
        n_a.mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        n_a.c   = c_prod[nrr_pkg::FAC_W+15:16];
        n_a.m   = i_data.m;
        n_a.h   = i_data.h;
    end

    // Stage B: rounded magnitude of the scaled offset.
    always_comb begin
        t_prod = {{(nrr_pkg::FAC_W+1){1'b0}}, r_a.mag} * {{(DIFF_W+1){1'b0}}, r_a.c}
               + {{(DIFF_W+nrr_pkg::FAC_W-16){1'b0}}, nrr_pkg::HALF_Q16};
        n_b.tm  = t_prod[TM_W+15:16];
        n_b.neg = r_a.neg;
        n_b.m   = r_a.m;
        n_b.h   = r_a.h;
    end

    // Stage C: add the rest potential back and saturate.
    always_comb begin
        t_s = r_b.neg ? -$signed({2'b00, r_b.tm}) : $signed({2'b00, r_b.tm});
        nv  = t_s + NV_W'($signed(i_cfg.rest_potential));
        if (nv > POT_MAX) begin
            n_c.pot = POT_MAX[nrr_pkg::POT_W-1:0];
        end else if (nv < POT_MIN) begin
            n_c.pot = POT_MIN[nrr_pkg::POT_W-1:0];
        end else begin
            n_c.pot = nv[nrr_pkg::POT_W-1:0];
        end
        n_c.m = r_b.m;
        n_c.h = r_b.h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
            r_c <= n_c;
        end
    end

    assign o_vld  = r_vld[2];
    assign o_data = r_c;

endmodule
`default_nettype wire

FILE: verif/tb_neuron_recovery_recharge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neuron_recovery_recharge
// Self-checking stream testbench of the neuron recovery and recharge block.
// ----------------------------------------------------------------------------
// Requests carrying a potential and a firing age are pushed through the slave
// stream while the master stream is drained with random back-pressure. Every
// accepted request is turned into an expected recharged potential and the two
// deficit factors by a bit-exact predictor. Results are compared in order.
// A short directed part hits the factor corner cases and potential
// saturation, then register settings are swept with random requests under
// several idling patterns on both sides.
// ----------------------------------------------------------------------------
module tb_neuron_recovery_recharge;

    localparam logic [nrr_pkg::POT_W-1:0] POT_MOST_NEG = 21'h100000;
    localparam logic [nrr_pkg::POT_W-1:0] POT_MOST_POS = 21'h0FFFFF;
    localparam longint POT_FLOOR = -1048576;
    localparam longint POT_CEIL  = 1048575;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_ITEMS = 167;
    localparam int REPORT_LIMIT  = 10;

    // One result of the block, laid out as the fields appear on the stream.
    typedef struct packed {
        logic [nrr_pkg::FAC_W-1:0] gain_factor;
        logic [nrr_pkg::FAC_W-1:0] recovery_factor;
        logic [nrr_pkg::POT_W-1:0] new_potential;
    } t_recharge;

    // Holds a copy of the register file, predicts the result of every
    // accepted request and checks results against those predictions in order.
    class recharge_ledger;
        logic signed [nrr_pkg::POT_W-1:0] rest_level;
        logic [nrr_pkg::UNIT_W-1:0]       leak_gain;
        logic [nrr_pkg::FAC_W-1:0]        m_reset;
        logic [nrr_pkg::UNIT_W-1:0]       m_decay;
        logic [nrr_pkg::FAC_W-1:0]        h_reset;
        logic [nrr_pkg::UNIT_W-1:0]       h_decay;
        t_recharge                        expected_recharge[$];
        int                               faults;

        function new();
            rest_level = '0;
            leak_gain  = nrr_pkg::ONE_Q16;
            m_reset    = nrr_pkg::ONE_Q16;
            m_decay    = '0;
            h_reset    = nrr_pkg::ONE_Q16;
            h_decay    = '0;
            faults     = 0;
        endfunction

        function void write_register(logic [nrr_pkg::IDX_W-1:0] idx,
                                     logic [nrr_pkg::CFG_W-1:0] value);
            case (idx)
                nrr_pkg::CFG_REST_POTENTIAL: rest_level = value[nrr_pkg::POT_W-1:0];
                nrr_pkg::CFG_LEAK_FACTOR:    leak_gain  = value[nrr_pkg::UNIT_W-1:0];
                nrr_pkg::CFG_RECOVERY_RESET: m_reset    = value[nrr_pkg::FAC_W-1:0];
                nrr_pkg::CFG_RECOVERY_DECAY: m_decay    = value[nrr_pkg::UNIT_W-1:0];
                nrr_pkg::CFG_GAIN_RESET:     h_reset    = value[nrr_pkg::FAC_W-1:0];
                nrr_pkg::CFG_GAIN_DECAY:     h_decay    = value[nrr_pkg::UNIT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned round_q16(longint unsigned a, longint unsigned b);
            return (a * b + nrr_pkg::HALF_Q16) >> 16;
        endfunction

        function logic [nrr_pkg::UNIT_W-1:0] limit_to_one(logic [nrr_pkg::UNIT_W-1:0] f);
            return (f > nrr_pkg::ONE_Q16) ? nrr_pkg::ONE_Q16 : f;
        endfunction

        // Factor that starts at r after firing and closes its distance to one
        // by mu per step. The age is already within the 16-bit power width.
        function logic [nrr_pkg::FAC_W-1:0] deficit_factor(logic [nrr_pkg::FAC_W-1:0] r,
                                                           logic [nrr_pkg::UNIT_W-1:0] mu,
                                                           logic [nrr_pkg::AGE_W-1:0] age);
            longint unsigned pw, base, d, e;
            int              i;
            if (age == 0 || r == nrr_pkg::ONE_Q16)
                return r;
            if (mu == 0)
                return nrr_pkg::ONE_Q16;
            if (mu == nrr_pkg::ONE_Q16)
                return r;
            pw   = nrr_pkg::ONE_Q16;
            base = mu;
            for (i = 0; i < nrr_pkg::AGE_W; i++) begin
                if (age[i])
                    pw = round_q16(pw, base);
                base = round_q16(base, base);
            end
            d = (r < nrr_pkg::ONE_Q16) ? nrr_pkg::ONE_Q16 - r : r - nrr_pkg::ONE_Q16;
            e = (d * pw + nrr_pkg::HALF_Q16) >> 16;
            return (r < nrr_pkg::ONE_Q16) ? nrr_pkg::ONE_Q16 - e : nrr_pkg::ONE_Q16 + e;
        endfunction

        function t_recharge predict(logic [nrr_pkg::POT_W-1:0] pot,
                                    logic [nrr_pkg::AGE_W-1:0] age);
            t_recharge       res;
            longint          v, diff, t, nv;
            longint unsigned m, h, c, mag, tm;
            v    = $signed(pot);
            m    = deficit_factor(m_reset, limit_to_one(m_decay), age);
            h    = deficit_factor(h_reset, limit_to_one(h_decay), age);
            c    = round_q16(limit_to_one(leak_gain), m);
            diff = v - rest_level;
            mag  = (diff < 0) ? -diff : diff;
            tm   = round_q16(mag, c);
            if (diff < 0)
                t = -longint'(tm);
            else
                t = longint'(tm);
            nv = rest_level + t;
            if (nv < POT_FLOOR)
                nv = POT_FLOOR;
            if (nv > POT_CEIL)
                nv = POT_CEIL;
            res.new_potential   = nv[nrr_pkg::POT_W-1:0];
            res.recovery_factor = m[nrr_pkg::FAC_W-1:0];
            res.gain_factor     = h[nrr_pkg::FAC_W-1:0];
            return res;
        endfunction

        function void note_request(logic [39:0] data);
            expected_recharge.push_back(
                predict(data[nrr_pkg::POT_W-1:0],
                        data[nrr_pkg::POT_W+nrr_pkg::AGE_W-1:nrr_pkg::POT_W]));
        endfunction

        function void check_result(logic [63:0] data);
            t_recharge want, got;
            got = data[nrr_pkg::POT_W+2*nrr_pkg::FAC_W-1:0];
            if (expected_recharge.size() == 0) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("unexpected result: pot %0d M %0d H %0d",
                             $signed(got.new_potential), got.recovery_factor,
                             got.gain_factor);
                return;
            end
            want = expected_recharge.pop_front();
            if (got != want) begin
                faults++;
                if (faults <= REPORT_LIMIT)
                    $display("mismatch: want pot %0d M %0d H %0d, got pot %0d M %0d H %0d",
                             $signed(want.new_potential), want.recovery_factor,
                             want.gain_factor, $signed(got.new_potential),
                             got.recovery_factor, got.gain_factor);
            end
        endfunction

        function int pending();
            return expected_recharge.size();
        endfunction
    endclass

    // All block inputs start at known values before the first clock edge.
    logic                        i_clk           = 1'b0;
    logic                        i_rst_n         = 1'b0;
    logic                        i_s_axis_tvalid = 1'b0;
    logic                        o_s_axis_tready;
    logic [39:0]                 i_s_axis_tdata  = '0;   // potential [20:0], firing_age [36:21]
    logic                        o_m_axis_tvalid;
    logic                        i_m_axis_tready = 1'b0;
    logic [63:0]                 o_m_axis_tdata;  // new_potential [20:0], M [40:21], H [60:41]
    logic                        i_cfg_we        = 1'b0;
    logic [nrr_pkg::IDX_W-1:0]   i_cfg_index     = '0;
    logic [nrr_pkg::CFG_W-1:0]   i_cfg_data      = '0;

    // Chance in percent that the sender inserts an idle cycle before a
    // request, and that the receiver holds ready low in a cycle.
    int send_idle_pct = 0;
    int stall_pct     = 0;

    recharge_ledger ledger;

    neuron_recovery_recharge DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // The receiver decides afresh every cycle whether it takes a result.
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Observes every edge. All stimulus changes through nonblocking
    // assignments, so the values read here are the ones the block saw at
    // this edge. Register writes are mirrored into the ledger at the same
    // edge at which the block takes them.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                ledger.write_register(i_cfg_index, i_cfg_data);
            if (o_m_axis_tvalid && i_m_axis_tready)
                ledger.check_result(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready)
                ledger.note_request(i_s_axis_tdata);
        end
    end

    // Offers one request, after a random run of idle cycles, and returns at
    // the edge at which it is taken. Valid stays high into the next request
    // unless that one starts with an idle cycle.
    task automatic send_request(input logic [nrr_pkg::POT_W-1:0] pot,
                                input logic [nrr_pkg::AGE_W-1:0] age);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b000, age, pot};
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
    endtask

    // Stops the stream and waits until every expected result has come back.
    // The first edge lets the monitor note the last request taken.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (ledger.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [nrr_pkg::IDX_W-1:0] idx,
                                  input logic [nrr_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
    endtask

    // Writes the whole register file in back-to-back cycles. Only called
    // while the pipeline holds no request.
    task automatic apply_settings(input logic [nrr_pkg::CFG_W-1:0] rest,
                                  input logic [nrr_pkg::CFG_W-1:0] leak,
                                  input logic [nrr_pkg::CFG_W-1:0] m_rst,
                                  input logic [nrr_pkg::CFG_W-1:0] m_dec,
                                  input logic [nrr_pkg::CFG_W-1:0] h_rst,
                                  input logic [nrr_pkg::CFG_W-1:0] h_dec);
        write_register(nrr_pkg::CFG_REST_POTENTIAL, rest);
        write_register(nrr_pkg::CFG_LEAK_FACTOR, leak);
        write_register(nrr_pkg::CFG_RECOVERY_RESET, m_rst);
        write_register(nrr_pkg::CFG_RECOVERY_DECAY, m_dec);
        write_register(nrr_pkg::CFG_GAIN_RESET, h_rst);
        write_register(nrr_pkg::CFG_GAIN_DECAY, h_dec);
        i_cfg_we <= 1'b0;
    endtask

    // Leak or decay value. Most picks sit just below one so that powers of
    // large ages do not all collapse to zero; some are above one, and some
    // carry junk above the register width.
    function automatic logic [nrr_pkg::CFG_W-1:0] pick_unit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16);
            2:       return nrr_pkg::CFG_W'($urandom());
            3:       return nrr_pkg::CFG_W'($urandom_range(65536));
            default: return nrr_pkg::CFG_W'($urandom_range(65535, 60000));
        endcase
    endfunction

    // Reset value of a deficit factor, below, at and above one.
    function automatic logic [nrr_pkg::CFG_W-1:0] pick_reset();
        case ($urandom_range(7))
            0:       return nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16);
            1:       return '0;
            2:       return nrr_pkg::CFG_W'(655360);
            3:       return nrr_pkg::CFG_W'(20'hFFFFF);
            4:       return nrr_pkg::CFG_W'($urandom());
            default: return nrr_pkg::CFG_W'($urandom_range(655360));
        endcase
    endfunction

    initial begin
        logic [nrr_pkg::POT_W-1:0] pot;
        logic [nrr_pkg::AGE_W-1:0] age;
        logic [nrr_pkg::CFG_W-1:0] rest;
        int                        seg, n;

        ledger = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: both reset factors are one, so both factors stay
        // one whatever the age, and the potential passes through unchanged.
        send_request(POT_MOST_NEG, 16'd0);
        send_request(POT_MOST_POS, 16'hFFFF);
        send_request('0, 16'd1);
        drain();

        // Decay of zero snaps M to one after a single step; decay of one
        // keeps H at its reset value; age zero returns the reset values.
        apply_settings('0, nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16), nrr_pkg::CFG_W'(32768), '0,
                       nrr_pkg::CFG_W'(131072), nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16));
        send_request(POT_MOST_POS, 16'd0);
        send_request(POT_MOST_NEG, 16'd1);
        send_request(21'h000801, 16'hFFFF);
        drain();

        // Leak and M decay written above one are treated as one. The M reset
        // is the largest 20-bit value, beyond its stated range, and a
        // potential far above the lowest rest level overflows upward.
        apply_settings(nrr_pkg::CFG_W'(POT_MOST_NEG), nrr_pkg::CFG_W'(17'h1FFFF),
                       nrr_pkg::CFG_W'(20'hFFFFF), nrr_pkg::CFG_W'(17'h1FFFF), '0,
                       nrr_pkg::CFG_W'(40000));
        send_request(POT_MOST_POS, 16'd1);
        send_request(POT_MOST_POS, 16'd3);
        send_request(21'h0ABCDE, 16'h8000);
        send_request(POT_MOST_NEG, 16'hFFFF);
        drain();

        // Highest rest level: a low potential scaled by a large M overflows
        // downward. Alternating age bits exercise both multiply paths.
        apply_settings(nrr_pkg::CFG_W'(POT_MOST_POS), nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16),
                       nrr_pkg::CFG_W'(655360), nrr_pkg::CFG_W'(65535), '0,
                       nrr_pkg::CFG_W'(1));
        send_request(POT_MOST_NEG, 16'd1);
        send_request(POT_MOST_NEG, 16'h5555);
        send_request(21'h1FFFFF, 16'hAAAA);
        send_request(POT_MOST_POS, 16'd2);
        drain();

        // Random part. Each segment loads fresh settings, the first two at
        // opposite extremes, and runs under one of four idling patterns.
        for (seg = 0; seg < SEGMENTS; seg++) begin
            case (seg % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                default: begin send_idle_pct = 35; stall_pct = 35; end
            endcase
            if (seg == 0) begin
                apply_settings(nrr_pkg::CFG_W'(POT_MOST_NEG),
                               nrr_pkg::CFG_W'(nrr_pkg::ONE_Q16),
                               nrr_pkg::CFG_W'(655360), nrr_pkg::CFG_W'(65535), '0,
                               nrr_pkg::CFG_W'(65535));
            end else if (seg == 1) begin
                apply_settings(nrr_pkg::CFG_W'(POT_MOST_POS), '0, '0, nrr_pkg::CFG_W'(1),
                               nrr_pkg::CFG_W'(655360), nrr_pkg::CFG_W'(1));
            end else begin
                case ($urandom_range(3))
                    0:       rest = nrr_pkg::CFG_W'(POT_MOST_NEG);
                    1:       rest = nrr_pkg::CFG_W'(POT_MOST_POS);
                    2:       rest = nrr_pkg::CFG_W'($urandom_range(8192))
                                  - nrr_pkg::CFG_W'(4096);
                    default: rest = nrr_pkg::CFG_W'($urandom());
                endcase
                apply_settings(rest, pick_unit(), pick_reset(), pick_unit(),
                               pick_reset(), pick_unit());
            end
            for (n = 0; n < SEGMENT_ITEMS; n++) begin
                case ($urandom_range(7))
                    0:       pot = POT_MOST_NEG;
                    1:       pot = POT_MOST_POS;
                    2:       pot = ledger.rest_level + nrr_pkg::POT_W'($urandom_range(4))
                                 - nrr_pkg::POT_W'(2);
                    default: pot = nrr_pkg::POT_W'($urandom());
                endcase
                // Small ages keep the powers away from zero so that the
                // rounding of the factor stays visible.
                case ($urandom_range(7))
                    0:       age = '0;
                    1:       age = 16'hFFFF;
                    2:       age = nrr_pkg::AGE_W'(1) << $urandom_range(15);
                    3, 4:    age = nrr_pkg::AGE_W'($urandom_range(24, 1));
                    default: age = nrr_pkg::AGE_W'($urandom());
                endcase
                send_request(pot, age);
            end
            drain();
        end

        // Anything arriving now has no request behind it.
        repeat (30) @(posedge i_clk);
        if (ledger.faults == 0 && ledger.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
rtl/nrr_pkg.sv
rtl/nrr_pow_stage.sv
rtl/nrr_factor.sv
rtl/nrr_recharge.sv
rtl/neuron_recovery_recharge.sv
verif/tb_neuron_recovery_recharge.sv
